// ===== src/r2a_pkg.sv =====
// Shared constants, types and the digit-to-ASCII mapping for the radix converter.
`default_nettype none
package r2a_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int VALUE_BITS = 31;

  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int DIGIT_W   = 6;
  localparam int ADDR_W    = $clog2(MAX_DIGITS);
  localparam int COUNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int DIV_CNT_W = $clog2(VALUE_BITS + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_BAD  = 7'h00;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // 0-9 then A-Z; anything past Z falls back to '0'.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DIGIT_W'(10)) begin
      digit_char = CHAR_ZERO + dx;
    end else if (d < DIGIT_W'(36)) begin
      digit_char = CHAR_A + dx - CHAR_W'(10);
    end else begin
      digit_char = CHAR_ZERO;
    end
  endfunction

endpackage
`default_nettype wire

// ===== src/r2a_divider.sv =====
// Restoring bit-serial divider: value / radix, one quotient bit per cycle.
`default_nettype none
module r2a_divider
  import r2a_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]    divisor,
  output div_stat_t                  stat,
  output logic      [VALUE_BITS-1:0] quot,
  output logic      [RADIX_W-1:0]    rem
);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [RADIX_W:0]      trial;
  logic [RADIX_W:0]      diff;
  logic                  fits;

  always_comb begin
    trial    = {rem_r, quo_r[VALUE_BITS-1]};
    diff     = trial - {1'b0, divisor};
    fits     = (trial >= {1'b0, divisor});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = DIV_CNT_W'(VALUE_BITS);
    end else if (cnt_r != '0) begin
      // remainder stays below the divisor, so it fits in RADIX_W bits
      rem_nxt  = fits ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      quo_nxt  = {quo_r[VALUE_BITS-2:0], fits};
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quot      = quo_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

// ===== src/r2a_digit_stack.sv =====
// Remainder stack storage: one write port, one registered read port.
`default_nettype none
module r2a_digit_stack
  import r2a_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [DIGIT_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  output logic      [DIGIT_W-1:0] rd_data
);

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== src/radix_to_ascii_digits_core.sv =====
// Top level: integer to ASCII digit string converter, radix 2 to 36.
`default_nettype none
// Converts a non-negative value into ASCII digits ('0'-'9', 'A'-'Z') in the
// requested radix, most significant digit first, one result request per
// digit, with out_last on the final digit. A zero value gives a single '0'.
// A radix outside 2..36 gives one result with out_bad_radix and out_last set
// and out_digit_char zero. A request is taken only when the block is idle.
// Each digit is computed in the bit-serial divider, which is instantiated
// once and reused for every digit; the remainders are pushed onto a small
// stack memory and then popped through S_RD, S_LD and S_OUT per digit,
// plus any wait on out_ready. The worst case is 31 digits (binary). A bad
// radix result goes straight from idle to S_OUT. No clearing pass is
// needed after reset.
module radix_to_ascii_digits_core
  import r2a_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [RADIX_W-1:0]    in_radix,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [CHAR_W-1:0]     out_digit_char,
  output logic                       out_last,
  output logic                       out_bad_radix
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;  // kick the divider
  localparam logic [2:0] S_DIV   = 3'd2;  // wait for quotient/remainder
  localparam logic [2:0] S_RD    = 3'd3;  // pop: read top of stack
  localparam logic [2:0] S_LD    = 3'd4;  // load popped digit into out reg
  localparam logic [2:0] S_OUT   = 3'd5;  // hold result until taken

  logic [2:0]            state_r, state_nxt;
  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [RADIX_W-1:0]    radix_r, radix_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_bad_r, out_bad_nxt;

  logic                  in_acc;
  logic                  out_acc;
  logic                  radix_bad;

  // divider hookup
  logic                  div_start;
  div_stat_t             div_stat;
  logic [VALUE_BITS-1:0] div_quot;
  logic [RADIX_W-1:0]    div_rem;

  // stack hookup
  logic                  stk_wr;
  logic                  stk_rd;
  logic [ADDR_W-1:0]     stk_wr_addr;
  logic [ADDR_W-1:0]     stk_rd_addr;
  logic [COUNT_W-1:0]    count_dec;
  logic [DIGIT_W-1:0]    stk_rd_data;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid_r && out_ready;
  assign radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);

  assign count_dec   = count_r - COUNT_W'(1);
  assign stk_wr_addr = count_r[ADDR_W-1:0];
  assign stk_rd_addr = count_dec[ADDR_W-1:0];

  r2a_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (radix_r),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  r2a_digit_stack u_stack (
    .clk     (clk),
    .wr_en   (stk_wr),
    .wr_addr (stk_wr_addr),
    .wr_data (DIGIT_W'(div_rem)),
    .rd_en   (stk_rd),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    radix_nxt     = radix_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    div_start     = 1'b0;
    stk_wr        = 1'b0;
    stk_rd        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (radix_bad) begin
            // single error result, stack untouched
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_BAD;
            out_last_nxt  = 1'b1;
            out_bad_nxt   = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            num_nxt   = in_value;
            radix_nxt = in_radix;
            count_nxt = '0;
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          // zero value naturally pushes one '0' digit here
          if (count_r < COUNT_W'(MAX_DIGITS)) begin
            stk_wr    = 1'b1;
            count_nxt = count_r + COUNT_W'(1);
          end
          num_nxt   = div_quot;
          state_nxt = (div_quot == '0) ? S_RD : S_START;
        end
      end
      S_RD: begin
        stk_rd    = 1'b1;
        count_nxt = count_dec;
        state_nxt = S_LD;
      end
      S_LD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = digit_char(stk_rd_data);
        out_last_nxt  = (count_r == '0);
        out_bad_nxt   = 1'b0;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    radix_r    <= radix_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_bad_radix  = out_bad_r;

  // divider only runs while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> (state_r == S_DIV))
    else $error("divider active outside S_DIV");

  // stack depth bounded
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_DIGITS))
    else $error("digit count overflow");

  // error result is always the only (last) one
  a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> out_last_r)
    else $error("bad radix result without last");

  // last digit leaves the stack empty
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (count_r == '0))
    else $error("last flagged with digits left");

endmodule
`default_nettype wire
